FILE: rtl/keyed_value_table_bsearch_unit_assert.svh
// Assertion macros shared by the table lookup RTL.
`ifndef KEYED_VALUE_TABLE_BSEARCH_UNIT_ASSERT_SVH
`define KEYED_VALUE_TABLE_BSEARCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define KVTBS_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KVTBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KVTBS_ASSERT(label, clk, rst, ante, cons)
`define KVTBS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/kvtbs_pkg.sv
`default_nettype none

package kvtbs_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = 8;
  localparam int COUNT_W     = 9;
  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 64;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_WRITE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SKIPPED   = 2'd2;

  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef struct packed {
    logic              done;
    logic              hit;
    logic [ADDR_W-1:0] slot;
  } srch_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/kvtbs_ram.sv
`default_nettype none

module kvtbs_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/kvtbs_search.sv
`default_nettype none

`include "keyed_value_table_bsearch_unit_assert.svh"

module kvtbs_search
  import kvtbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [KEY_W-1:0]   key,
  input  wire logic [COUNT_W-1:0] count,
  input  wire logic [KEY_W-1:0]   key_rdata,
  output logic      [ADDR_W-1:0]  key_raddr,
  output srch_rsp_t               rsp
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FIRST = 4'b0010,
    S_LAST  = 4'b0100,
    S_MID   = 4'b1000
  } srch_state_t;

  srch_state_t        state, state_next;
  logic [ADDR_W-1:0]  base, base_next;
  logic [COUNT_W-1:0] span, span_next;
  logic [ADDR_W-1:0]  addr, addr_next;
  logic [KEY_W-1:0]   key_q;

  logic               fin, fin_hit;
  logic               key_eq, key_gt;
  logic [COUNT_W-1:0] half, span_gt, half_gt;
  logic [ADDR_W-1:0]  last_addr, mid_addr, mid_gt_addr, last_lt_addr;

  always_comb begin
    key_eq       = key_rdata == key_q;
    key_gt       = key_q > key_rdata;
    half         = span >> 1;
    last_addr    = ADDR_W'(COUNT_W'(base) + span - COUNT_W'(1));
    mid_addr     = ADDR_W'(COUNT_W'(base) + half);
    span_gt      = span - half;
    half_gt      = span_gt >> 1;
    mid_gt_addr  = ADDR_W'(COUNT_W'(mid_addr) + half_gt);
    last_lt_addr = ADDR_W'(COUNT_W'(base) + half - COUNT_W'(1));
  end

  always_comb begin
    state_next = state;
    base_next  = base;
    span_next  = span;
    addr_next  = addr;
    fin        = 1'b0;
    fin_hit    = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (count == '0) begin
            fin = 1'b1;
          end else begin
            base_next  = '0;
            span_next  = count;
            addr_next  = '0;
            state_next = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (key_eq) begin
          fin     = 1'b1;
          fin_hit = 1'b1;
        end else begin
          addr_next  = last_addr;
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        if (key_eq) begin
          fin     = 1'b1;
          fin_hit = 1'b1;
        end else if (half == '0) begin
          fin = 1'b1;
        end else begin
          addr_next  = mid_addr;
          state_next = S_MID;
        end
      end
      S_MID: begin
        if (key_eq) begin
          fin     = 1'b1;
          fin_hit = 1'b1;
        end else if (key_gt) begin
          base_next = mid_addr;
          span_next = span_gt;
          if (half_gt == '0) begin
            fin = 1'b1;
          end else begin
            addr_next = mid_gt_addr;
          end
        end else begin
          span_next  = half;
          addr_next  = last_lt_addr;
          state_next = S_LAST;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin) begin
      state_next = S_IDLE;
    end
  end

  assign key_raddr = addr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      state    <= state_next;
      rsp.done <= fin;
    end
    base     <= base_next;
    span     <= span_next;
    addr     <= addr_next;
    rsp.hit  <= fin_hit;
    rsp.slot <= fin_hit ? addr : '0;
    if (state == S_IDLE && start) begin
      key_q <= key;
    end
  end

  `KVTBS_ASSERT_NEXT(a_empty_miss, clk, rst,
                     (state == S_IDLE) && start && (count == '0), rsp.done && !rsp.hit)
  `KVTBS_ASSERT(a_mid_span, clk, rst, state == S_MID, span >= COUNT_W'(2))
  `KVTBS_ASSERT(a_range_in_table, clk, rst, state != S_IDLE,
                (10'(base) + 10'(span)) <= 10'(TABLE_DEPTH))
  `KVTBS_ASSERT_NEXT(a_done_pulse, clk, rst, rsp.done, !rsp.done)

endmodule

`default_nettype wire

FILE: rtl/keyed_value_table_bsearch_unit.sv
`default_nettype none

`include "keyed_value_table_bsearch_unit_assert.svh"

// Keyed value table with a binary-search lookup over up to 256 entries. An item
// is taken when start is high and busy is low; each load, read or write gives
// one result, shown for exactly one cycle with done high, and the receiver
// cannot hold it off. An item with func code 3 is ignored and gives none. A read
// or write probes the key memory once per cycle through a single comparator:
// first slot, last slot, then one middle probe per halving (plus a last-slot
// probe when the range shrinks from above), so a lookup of n entries takes
// about 1 to 2*log2(n)+2 probes; done is registered from the search response,
// and a read hit then reads the value memory before done. An empty table
// answers a miss without probing. busy drops in the cycle that shows the result.
module keyed_value_table_bsearch_unit
  import kvtbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [FUNC_W-1:0]     func,
  input  wire logic [ADDR_W-1:0]     load_index,
  input  wire logic [KEY_W-1:0]      key,
  input  wire logic [VALUE_W-1:0]    write_value,
  input  wire logic                  last_in_batch,
  output logic                       done,
  output logic      [STATUS_W-1:0]   status,
  output logic      [VALUE_W-1:0]    read_value,
  output logic      [ADDR_W-1:0]     found_slot
);

  typedef enum logic [2:0] {
    T_IDLE   = 3'b001,
    T_SEARCH = 3'b010,
    T_VREAD  = 3'b100
  } top_state_t;

  top_state_t         state;
  logic [COUNT_W-1:0] entry_count;
  logic [COUNT_W-1:0] n_sat;
  logic               batch_failed;
  logic [FUNC_W-1:0]  func_q;
  logic               last_q;
  logic [VALUE_W-1:0] wval_q;

  logic               accept, is_load, is_lookup, load_ok, srch_start;
  srch_rsp_t          srsp;

  logic               key_we;
  logic [ADDR_W-1:0]  key_raddr;
  logic [KEY_W-1:0]   key_rdata;

  logic               val_we;
  logic [ADDR_W-1:0]  val_waddr;
  logic [VALUE_W:0]   val_wdata;
  logic [VALUE_W:0]   val_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENTRY_COUNT) ?
                  APB_DATA_W'(entry_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENTRY_COUNT) begin
      entry_count <= pwdata[COUNT_W-1:0];
    end
  end

  assign n_sat = (entry_count > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : entry_count;

  assign busy       = state != T_IDLE;
  assign accept     = start && !busy;
  assign is_load    = func == FN_LOAD;
  assign is_lookup  = func == FN_READ || func == FN_WRITE;
  assign load_ok    = COUNT_W'(load_index) < COUNT_W'(TABLE_DEPTH);
  assign srch_start = accept && is_lookup && !batch_failed;
  assign key_we     = accept && is_load && load_ok;

  always_comb begin
    if (state == T_IDLE) begin
      val_we    = key_we;
      val_waddr = load_index;
      val_wdata = '0;
    end else begin
      val_we    = state == T_SEARCH && srsp.done && srsp.hit && func_q == FN_WRITE;
      val_waddr = srsp.slot;
      val_wdata = {1'b1, wval_q};
    end
  end

  kvtbs_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(KEY_W)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (load_index),
    .wdata (key),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  kvtbs_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(VALUE_W + 1)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (srsp.slot),
    .rdata (val_rdata)
  );

  kvtbs_search u_search (
    .clk       (clk),
    .rst       (rst),
    .start     (srch_start),
    .key       (key),
    .count     (n_sat),
    .key_rdata (key_rdata),
    .key_raddr (key_raddr),
    .rsp       (srsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      done         <= 1'b0;
      batch_failed <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        T_IDLE: begin
          if (accept && is_load) begin
            done       <= 1'b1;
            status     <= ST_OK;
            read_value <= '0;
            found_slot <= '0;
          end else if (accept && is_lookup) begin
            if (batch_failed) begin
              done       <= 1'b1;
              status     <= ST_SKIPPED;
              read_value <= '0;
              found_slot <= '0;
              if (last_in_batch) begin
                batch_failed <= 1'b0;
              end
            end else begin
              state <= T_SEARCH;
            end
          end
        end
        T_SEARCH: begin
          if (srsp.done) begin
            if (!srsp.hit) begin
              done         <= 1'b1;
              status       <= ST_NOT_FOUND;
              read_value   <= '0;
              found_slot   <= '0;
              batch_failed <= !last_q;
              state        <= T_IDLE;
            end else if (func_q == FN_WRITE) begin
              done       <= 1'b1;
              status     <= ST_OK;
              read_value <= '0;
              found_slot <= srsp.slot;
              state      <= T_IDLE;
            end else begin
              found_slot <= srsp.slot;
              state      <= T_VREAD;
            end
          end
        end
        T_VREAD: begin
          done       <= 1'b1;
          status     <= ST_OK;
          read_value <= val_rdata[VALUE_W-1:0];
          state      <= T_IDLE;
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      last_q <= last_in_batch;
      wval_q <= write_value;
    end
  end

  `KVTBS_ASSERT_NEXT(a_skip_next, clk, rst, accept && is_lookup && batch_failed,
                     done && status == ST_SKIPPED)
  `KVTBS_ASSERT(a_miss_zero, clk, rst, done && status == ST_NOT_FOUND,
                found_slot == '0 && read_value == '0)
  `KVTBS_ASSERT(a_rsp_in_search, clk, rst, srsp.done, state == T_SEARCH)

endmodule

`default_nettype wire
